@@ hw/rtl/sls_pkg.sv @@
package sls_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned TickW   = 32;
  localparam int unsigned AccW    = 32;
  localparam int unsigned LevelW  = 8;
  localparam int unsigned CfgIdxW = 1;

  localparam int unsigned MsPerSec    = 1000;
  localparam int unsigned SecPerMin   = 60;
  localparam int unsigned MinPerHour  = 60;
  localparam int unsigned HoursPerDay = 24;
  localparam int unsigned PeriodSec   = 5;

  localparam logic [TickW-1:0] SamplePeriodReset = TickW'(PeriodSec * MsPerSec);
  localparam logic [TickW-1:0] RestartGapReset   =
      TickW'(HoursPerDay * MinPerHour * SecPerMin * MsPerSec);

  typedef enum logic [CfgIdxW-1:0] {
    REG_SAMPLE_PERIOD = 1'b0,
    REG_RESTART_GAP   = 1'b1
  } cfg_reg_e;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_GAP    = 5'b00010,
    ST_DECIDE = 5'b00100,
    ST_DIV    = 5'b01000,
    ST_OUT    = 5'b10000
  } sls_state_e;

  typedef struct packed {
    logic             start;
    logic [AccW-1:0]  dividend;
    logic [AccW-1:0]  divisor;
  } div_req_t;

endpackage

@@ hw/rtl/sls_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
module sls_div
  import sls_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  div_req_t        req_i,
  output logic            done_o,
  output logic [AccW-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(AccW);
  localparam logic [CntW-1:0] LastCnt = CntW'(AccW - 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [AccW-1:0] quo_q, quo_d;
  logic [AccW-1:0] rem_q, rem_d;
  logic [AccW-1:0] den_q, den_d;
  logic [AccW:0]   trial;
  logic [AccW:0]   diff;

  assign trial = {rem_q, quo_q[AccW-1]};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      den_d  = req_i.divisor;
    end else if (busy_q) begin
      // keep the difference when the trial remainder covers the divisor
      if (!diff[AccW]) begin
        rem_d = diff[AccW-1:0];
        quo_d = {quo_q[AccW-2:0], 1'b1};
      end else begin
        rem_d = trial[AccW-1:0];
        quo_d = {quo_q[AccW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastCnt) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("divider done held longer than one cycle");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without a running division");

  a_no_restart_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !req_i.start)
    else $error("divider started while busy");

endmodule

@@ hw/rtl/signal_level_statistics.sv @@
// Running statistics of a signal-strength reading. Each request carries a
// 16-bit sample and a 32-bit tick time; each one yields exactly one result
// with the low byte of the sample and the current max, min and mean. The
// first sample after reset or after a restart seeds all statistics. Later,
// a tick gap (modulo 2^32) of at least restart_gap_ticks only arms a restart
// that the next sample carries out; a gap of at least sample_period_ticks
// folds the sample into max, min, sum and count and recomputes the mean as
// the truncated sum / count. The block takes one request at a time: a seed
// passes the capture and gap states to the result, a restart arm or a dropped
// sample also the decide state, and an accepted sample then waits in the
// divide state for the radix-2 divider that produces one quotient bit per
// cycle. The next request is taken in the cycle after the result is taken.
// Configuration: index 0 is sample_period_ticks (reset 5000), index 1 is
// restart_gap_ticks (reset 86400000); write them only while the block is idle.
module signal_level_statistics
  import sls_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [TickW-1:0]   cfg_data_i,
  // sample request channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [SampleW-1:0] signal_sample_i,
  input  logic [TickW-1:0]   now_tick_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [LevelW-1:0]  current_level_o,
  output logic [SampleW-1:0] level_max_o,
  output logic [SampleW-1:0] level_min_o,
  output logic [SampleW-1:0] level_mean_o
);

  sls_state_e state_q, state_d;

  // configuration registers
  logic [TickW-1:0] period_q, period_d;
  logic [TickW-1:0] restart_q, restart_d;

  // statistics state
  logic               need_seed_q, need_seed_d;
  logic [TickW-1:0]   last_time_q, last_time_d;
  logic [AccW-1:0]    sum_q, sum_d;
  logic [AccW-1:0]    count_q, count_d;
  logic [SampleW-1:0] max_q, max_d;
  logic [SampleW-1:0] min_q, min_d;
  logic [SampleW-1:0] mean_q, mean_d;

  // captured request and the tick gap
  logic [SampleW-1:0] sample_q, sample_d;
  logic [TickW-1:0]   now_q, now_d;
  logic [TickW-1:0]   gap_q, gap_d;

  logic            in_fire;
  logic            out_fire;
  logic            cfg_fire;
  logic            take_sample;
  logic [AccW-1:0] sum_next;
  logic [AccW-1:0] count_next;
  div_req_t        div_req;
  logic            div_done;
  logic [AccW-1:0] div_quotient;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == ST_OUT);
  assign out_fire    = out_valid_o && out_ready_i;

  // restart test wins over the period test
  assign take_sample = (gap_q < restart_q) && (gap_q >= period_q);
  assign sum_next    = sum_q + AccW'(sample_q);
  assign count_next  = count_q + 1'b1;

  // a zero count after wrap divides by zero, which the divider answers with all ones
  assign div_req.start    = (state_q == ST_DECIDE) && take_sample;
  assign div_req.dividend = sum_next;
  assign div_req.divisor  = count_next;

  sls_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .done_o     (div_done),
    .quotient_o (div_quotient)
  );

  // configuration writes
  always_comb begin
    period_d  = period_q;
    restart_d = restart_q;
    if (cfg_fire) begin
      case (cfg_index_i)
        REG_SAMPLE_PERIOD: period_d  = cfg_data_i;
        REG_RESTART_GAP:   restart_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    need_seed_d = need_seed_q;
    last_time_d = last_time_q;
    sum_d       = sum_q;
    count_d     = count_q;
    max_d       = max_q;
    min_d       = min_q;
    mean_d      = mean_q;
    sample_d    = sample_q;
    now_d       = now_q;
    gap_d       = gap_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          sample_d = signal_sample_i;
          now_d    = now_tick_i;
          state_d  = ST_GAP;
        end
      end
      ST_GAP: begin
        if (need_seed_q) begin
          // seed every statistic from this sample
          last_time_d = now_q;
          max_d       = sample_q;
          min_d       = sample_q;
          mean_d      = sample_q;
          sum_d       = AccW'(sample_q);
          count_d     = AccW'(1);
          need_seed_d = 1'b0;
          state_d     = ST_OUT;
        end else begin
          gap_d   = now_q - last_time_q;
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (gap_q >= restart_q) begin
          // arm only; the next request reseeds
          need_seed_d = 1'b1;
          state_d     = ST_OUT;
        end else if (take_sample) begin
          count_d     = count_next;
          sum_d       = sum_next;
          last_time_d = now_q;
          if (sample_q > max_q) begin
            max_d = sample_q;
          end
          if (sample_q < min_q) begin
            min_d = sample_q;
          end
          state_d = ST_DIV;
        end else begin
          // gap below the period: hold the statistics
          state_d = ST_OUT;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          mean_d  = div_quotient[SampleW-1:0];
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_fire) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      period_q    <= SamplePeriodReset;
      restart_q   <= RestartGapReset;
      need_seed_q <= 1'b1;
      last_time_q <= '0;
      sum_q       <= '0;
      count_q     <= '0;
      max_q       <= '0;
      min_q       <= '0;
      mean_q      <= '0;
    end else begin
      state_q     <= state_d;
      period_q    <= period_d;
      restart_q   <= restart_d;
      need_seed_q <= need_seed_d;
      last_time_q <= last_time_d;
      sum_q       <= sum_d;
      count_q     <= count_d;
      max_q       <= max_d;
      min_q       <= min_d;
      mean_q      <= mean_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    now_q    <= now_d;
    gap_q    <= gap_d;
  end

  assign current_level_o = sample_q[LevelW-1:0];
  assign level_max_o     = max_q;
  assign level_min_o     = min_q;
  assign level_mean_o    = mean_q;

  a_ready_xor_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("request taken while a result is pending");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o && !out_valid_o)
    else $error("request not held in work for a cycle");

  a_done_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |=> out_valid_o)
    else $error("division result did not reach the output");

  a_ready_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire |=> in_ready_o)
    else $error("block not ready after the result was taken");

endmodule

@@ sim/tb_signal_level_statistics.sv @@
`timescale 1ns / 1ps

// One result as the block presents it.
typedef struct packed {
  logic [sls_pkg::LevelW-1:0]  current;
  logic [sls_pkg::SampleW-1:0] peak;
  logic [sls_pkg::SampleW-1:0] floor_lvl;
  logic [sls_pkg::SampleW-1:0] mean;
} level_stats_t;

// Running-statistics tracker: folds each accepted request into its own copy
// of the block state and queues the level report that the block owes for it.
class level_tracker;
  logic [sls_pkg::TickW-1:0]   period_ticks  = sls_pkg::SamplePeriodReset;
  logic [sls_pkg::TickW-1:0]   restart_ticks = sls_pkg::RestartGapReset;
  bit                          reseed        = 1'b1;
  logic [sls_pkg::TickW-1:0]   rec_tick      = '0;
  logic [sls_pkg::AccW-1:0]    level_sum     = '0;
  logic [sls_pkg::AccW-1:0]    level_count   = '0;
  logic [sls_pkg::SampleW-1:0] peak          = '0;
  logic [sls_pkg::SampleW-1:0] floor_lvl     = '0;
  logic [sls_pkg::SampleW-1:0] mean          = '0;
  level_stats_t                levels_q[$];
  int unsigned                 mismatches    = 0;

  task report(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    mismatches++;
  endtask

  function void write_reg(input sls_pkg::cfg_reg_e idx, input logic [31:0] data);
    case (idx)
      sls_pkg::REG_SAMPLE_PERIOD: period_ticks = data;
      sls_pkg::REG_RESTART_GAP:   restart_ticks = data;
      default: ;
    endcase
  endfunction

  function void fold_sample(input logic [15:0] level, input logic [31:0] now);
    logic [31:0] gap;
    level_stats_t owed;
    if (reseed) begin
      rec_tick    = now;
      peak        = level;
      floor_lvl   = level;
      mean        = level;
      level_sum   = {16'h0, level};
      level_count = 32'd1;
      reseed      = 1'b0;
    end else begin
      gap = now - rec_tick;
      // the restart test wins over the period test
      if (gap >= restart_ticks) begin
        reseed = 1'b1;
      end else if (gap >= period_ticks) begin
        level_count = level_count + 32'd1;
        if (level > peak) peak = level;
        if (level < floor_lvl) floor_lvl = level;
        level_sum = level_sum + {16'h0, level};
        if (level_count == '0) mean = 16'hFFFF;
        else mean = 16'(level_sum / level_count);
        rec_tick = now;
      end
    end
    owed.current   = level[7:0];
    owed.peak      = peak;
    owed.floor_lvl = floor_lvl;
    owed.mean      = mean;
    levels_q.push_back(owed);
  endfunction

  task compare_levels(input level_stats_t got);
    level_stats_t want;
    if (levels_q.size() == 0) begin
      report($sformatf("result with nothing owed: %h", got));
      return;
    end
    want = levels_q.pop_front();
    if (got.current != want.current)
      report($sformatf("current_level %h, want %h", got.current, want.current));
    if (got.peak != want.peak)
      report($sformatf("level_max %h, want %h", got.peak, want.peak));
    if (got.floor_lvl != want.floor_lvl)
      report($sformatf("level_min %h, want %h", got.floor_lvl, want.floor_lvl));
    if (got.mean != want.mean)
      report($sformatf("level_mean %h, want %h", got.mean, want.mean));
  endtask

  task flush_leftovers();
    while (levels_q.size() != 0)
      report($sformatf("result never came: %h", levels_q.pop_front()));
  endtask
endclass

module tb_signal_level_statistics;
  import sls_pkg::*;

  typedef enum int unsigned {RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT} rx_mode_e;

  // Drive every input to a known value from time zero.
  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_valid   = 1'b0;
  cfg_reg_e           cfg_index   = REG_SAMPLE_PERIOD;
  logic [TickW-1:0]   cfg_data    = '0;
  logic               in_valid    = 1'b0;
  logic [SampleW-1:0] sample      = '0;
  logic [TickW-1:0]   tick        = '0;
  logic               out_ready   = 1'b0;

  logic               cfg_ready_o;
  logic               in_ready_o;
  logic               out_valid_o;
  logic [LevelW-1:0]  current_level_o;
  logic [SampleW-1:0] level_max_o;
  logic [SampleW-1:0] level_min_o;
  logic [SampleW-1:0] level_mean_o;

  level_tracker stats = new;

  // Sender burst bookkeeping and the request for a long receiver hold.
  int unsigned burst_left = 0;
  bit          hold_rx    = 1'b0;

  signal_level_statistics u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .signal_sample_i(sample),
    .now_tick_i     (tick),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .current_level_o(current_level_o),
    .level_max_o    (level_max_o),
    .level_min_o    (level_min_o),
    .level_mean_o   (level_mean_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Abort a hung run.
  initial begin
    #10_000_000;
    $display("tb_signal_level_statistics: errors");
    $finish;
  end

  // Offer one request and hold it until the block takes it, then fold it
  // into the tracker right at the accepting edge.
  task automatic offer(input logic [15:0] level, input logic [31:0] now);
    in_valid <= 1'b1;
    sample   <= level;
    tick     <= now;
    do @(posedge clk_i); while (!in_ready_o);
    stats.fold_sample(level, now);
  endtask

  // Close a burst now and then: drop valid for a random gap, or keep going.
  task automatic pace();
    int unsigned idle;
    if (burst_left == 0) begin
      burst_left = $urandom_range(30, 1);
      idle = ($urandom_range(3) == 0) ? 0 : $urandom_range(40, 1);
      if (idle != 0) begin
        in_valid <= 1'b0;
        repeat (idle) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  // Pause the sender until every owed result is back or the spin limit runs
  // out, then let the block settle.
  task automatic drain(input int unsigned limit);
    int unsigned spins = 0;
    in_valid <= 1'b0;
    while (stats.levels_q.size() != 0 && spins < limit) begin
      @(posedge clk_i);
      spins++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  // Write both registers back to back; valid stays high across the pair.
  task automatic set_limits(input logic [31:0] period, input logic [31:0] restart);
    cfg_valid <= 1'b1;
    cfg_index <= REG_SAMPLE_PERIOD;
    cfg_data  <= period;
    do @(posedge clk_i); while (!cfg_ready_o);
    stats.write_reg(REG_SAMPLE_PERIOD, period);
    cfg_index <= REG_RESTART_GAP;
    cfg_data  <= restart;
    do @(posedge clk_i); while (!cfg_ready_o);
    stats.write_reg(REG_RESTART_GAP, restart);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] span(input logic [31:0] lo, input logic [31:0] hi);
    if (hi <= lo) return lo;
    return $urandom_range(hi, lo);
  endfunction

  // Pick a tick relative to the last recorded time so that most requests
  // land in the accept window, with drops, restarts, boundaries and noise.
  function automatic logic [31:0] pick_tick();
    logic [31:0] per = stats.period_ticks;
    logic [31:0] rst = stats.restart_ticks;
    logic [31:0] gap;
    int unsigned k = $urandom_range(99);
    if (k < 50)      gap = span(per, rst - 32'd1);
    else if (k < 65) gap = (per == '0) ? '0 : span('0, per - 32'd1);
    else if (k < 75) gap = span(rst, 32'hFFFF_FFFF);
    else if (k < 80) gap = per;
    else if (k < 85) gap = rst - 32'd1;
    else if (k < 90) gap = rst;
    else return $urandom();
    return stats.rec_tick + gap;
  endfunction

  function automatic logic [15:0] pick_level();
    int unsigned k = $urandom_range(9);
    if (k == 0) return 16'h0000;
    if (k == 1) return 16'hFFFF;
    return 16'($urandom());
  endfunction

  // Receiver: check each accepted result against the oldest owed report,
  // then choose ready for the next cycle. A hold request parks ready low for
  // a long stretch so that the block backs up and stalls its input.
  initial begin
    int unsigned run_left  = 0;
    int unsigned hold_left = 0;
    int unsigned beat      = 0;
    rx_mode_e    mode      = RX_OPEN;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready)
        stats.compare_levels({current_level_o, level_max_o, level_min_o, level_mean_o});
      if (hold_rx && hold_left == 0) begin
        hold_left = 400;
        hold_rx   = 1'b0;
      end
      beat++;
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (run_left == 0) begin
          mode     = rx_mode_e'($urandom_range(3));
          run_left = $urandom_range(200, 20);
        end
        run_left--;
        case (mode)
          RX_OPEN:   out_ready <= 1'b1;
          RX_COIN:   out_ready <= 1'($urandom_range(1));
          RX_SPARSE: out_ready <= ($urandom_range(3) == 0);
          default:   out_ready <= (beat % 3 != 0);
        endcase
      end
    end
  end

  // Stimulus: directed corners at the reset settings, then the register
  // extremes, then random phases under varied settings.
  initial begin
    logic [31:0] per;
    logic [31:0] rst;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // seed, then one tick short of the period: hold the stats
    offer(16'h1234, 32'd1000);
    offer(16'hFFFF, stats.rec_tick + 32'd4999);
    // exactly one period: accept a new max
    offer(16'hFFFF, stats.rec_tick + 32'd5000);
    // one tick short of the restart gap: accept a new min
    offer(16'h0000, stats.rec_tick + RestartGapReset - 32'd1);
    offer(16'h00FF, stats.rec_tick + 32'd1);
    // exactly the restart gap: arm only, then reseed near the tick wrap
    offer(16'hABCD, stats.rec_tick + RestartGapReset);
    offer(16'h8001, 32'hFFFF_F000);
    // tick wraps past zero
    offer(16'h0001, stats.rec_tick + 32'd6000);
    offer(16'h5555, stats.rec_tick + 32'd5000);
    offer(16'hAAAA, stats.rec_tick + 32'd7000);
    offer(16'h7FFF, stats.rec_tick + 32'hFFFF_FFFF);
    offer(16'h0F0F, $urandom());
    drain(20000);

    // zero period: every gap, even zero, accepts
    set_limits('0, '1);
    offer(16'hF0F0, stats.rec_tick);
    offer(16'h0000, stats.rec_tick);
    offer(16'hFFFF, stats.rec_tick + 32'd1);
    drain(20000);

    // zero restart gap: each request after a seed only arms, and the next one reseeds
    set_limits(32'd1, '0);
    offer(16'h3C3C, stats.rec_tick + 32'd1);
    offer(16'hC3C3, stats.rec_tick + 32'd1);
    offer(16'h1111, stats.rec_tick + 32'd1);
    drain(20000);

    // both registers at max: a full gap meets both, so restart wins
    set_limits('1, '1);
    offer(16'h2222, stats.rec_tick + 32'hFFFF_FFFE);
    offer(16'h4444, stats.rec_tick + 32'hFFFF_FFFF);
    offer(16'h8888, stats.rec_tick + 32'd3);
    drain(20000);

    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: set_limits(32'd1, '1);
        1: set_limits('1, '1);
        2: set_limits(SamplePeriodReset, RestartGapReset);
        8: set_limits($urandom(), $urandom());
        default: begin
          per = $urandom_range(50000, 1);
          rst = per + $urandom_range(2_000_000, 1);
          set_limits(per, rst);
        end
      endcase
      // back up the block behind a stalled receiver once
      if (ph == 4) hold_rx = 1'b1;
      for (int i = 0; i < 100; i++) begin
        offer(pick_level(), pick_tick());
        pace();
      end
      drain(200000);
    end

    stats.flush_leftovers();
    repeat (40) @(posedge clk_i);
    if (stats.mismatches == 0) begin
      $display("tb_signal_level_statistics: clean");
    end else begin
      $display("tb_signal_level_statistics: errors");
    end
    $finish;
  end

endmodule
